[hw/rtl/cte_pkg.sv]
`timescale 1ns / 1ps
// Shared constants of the complementary tilt estimator.
// No dependencies; imported by every module of the block.
package cte_pkg;

  // Register indexes on the configuration port (byte address 4*index)
  localparam logic [1:0] REG_GYRO_BIAS    = 2'd0;
  localparam logic [1:0] REG_ACCEL_OFFSET = 2'd1;
  localparam logic [1:0] REG_BLEND_WEIGHT = 2'd2;
  localparam logic [1:0] REG_TILT_LIMIT   = 2'd3;

  // Register reset values
  localparam logic signed [15:0] GYRO_BIAS_RST    = -16'sd75;
  localparam logic signed [12:0] ACCEL_OFFSET_RST = -13'sd1075;
  localparam logic [15:0]        BLEND_WEIGHT_RST = 16'd655;
  localparam logic [15:0]        TILT_LIMIT_RST   = 16'd11520;

  // Angle saturation, +-180 degrees in 1/256 degree
  localparam logic signed [16:0] ANGLE_MAX = 17'sd46080;

  // CORDIC datapath widths
  localparam int CORDIC_XY_W = 27;
  localparam int CORDIC_Z_W  = 26;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // atan(2^-i) in degrees, Q16
  localparam logic [21:0] ATAN_Q16 [ATAN_ENTRIES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // Serial blend multiplier: 19-bit signed difference times 16-bit weight
  localparam int DIFF_W    = 19;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = DIFF_W + WEIGHT_W;
  localparam int MUL_CNT_W = $clog2(WEIGHT_W);

endpackage

[hw/rtl/cte_cordic.sv]
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: atan2(y, x) in 1/256 degree, one iteration a cycle.
// Depends on cte_pkg for the arctangent table and datapath widths.
module cte_cordic
  import cte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  y_in,
  input  logic signed [15:0]  x_in,
  output logic                done,
  output logic signed [16:0]  angle
);

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic signed [CORDIC_Z_W-1:0] Z_90 = CORDIC_Z_W'(90 * 65536);
  localparam logic signed [CORDIC_Z_W-1:0] Z_HALF = CORDIC_Z_W'(128);

  logic signed [CORDIC_XY_W-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [CORDIC_Z_W-1:0]  z, z_next, z0, zr, atan_val;
  logic signed [16:0]            xs, ys, x0, y0;
  logic [STEP_W-1:0]             cnt;
  logic [ATAN_IDX_W-1:0]         idx;
  logic                          busy, zero;

  // Pre-rotate by +-90 degrees when x is negative
  always_comb begin
    xs = {x_in[15], x_in};
    ys = {y_in[15], y_in};
    z0 = '0;
    x0 = xs;
    y0 = ys;
    if (xs < 0) begin
      if (ys >= 0) begin
        z0 = Z_90;
        x0 = ys;
        y0 = -xs;
      end else begin
        z0 = -Z_90;
        x0 = -ys;
        y0 = xs;
      end
    end
  end

  always_comb begin
    idx      = ATAN_IDX_W'(cnt);
    atan_val = $signed({4'b0, ATAN_Q16[idx]});
    dx       = y >>> cnt;
    dy       = x >>> cnt;
    if (y >= 0) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + atan_val;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= {{2{x0[16]}}, x0, 8'b0};
      y    <= {{2{y0[16]}}, y0, 8'b0};
      z    <= z0;
      zero <= (x_in == 16'sd0) && (y_in == 16'sd0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Round half up to 1/256 degree
  assign zr    = z + Z_HALF;
  assign angle = zero ? 17'sd0 : zr[24:8];

endmodule

[hw/rtl/cte_mul.sv]
`timescale 1ns / 1ps
// Bit-serial multiplier: signed difference times unsigned weight, MSB first.
// Depends on cte_pkg for operand widths.
module cte_mul
  import cte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] a,
  input  logic [WEIGHT_W-1:0]      b,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [DIFF_W-1:0] a_reg;
  logic [WEIGHT_W-1:0]      b_sr;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     busy;
  logic signed [PROD_W-1:0] addend;

  assign addend = b_sr[WEIGHT_W-1] ? PROD_W'(a_reg) : '0;

  // Shift the weight out one bit a cycle, accumulate the product
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sr  <= b;
      prod  <= '0;
    end else if (busy) begin
      prod <= (prod <<< 1) + addend;
      b_sr <= b_sr << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(WEIGHT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/complementary_tilt_estimator.sv]
`timescale 1ns / 1ps
// Complementary tilt estimator, top level. An accepted word runs through the iterative
// CORDIC unit and then the bit-serial blend multiplier. One word is in flight at a time,
// so a new word is taken only after the result has been handed to the output register.
// Reset (rst, synchronous) restores register defaults, clears the angle and drops the output valid.
// Uses cte_pkg, cte_cordic and cte_mul.
module complementary_tilt_estimator
  import cte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x [15:0], accel_z [31:16], gyro_y [47:32]
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // tilt_angle [16:0], accel_angle [33:17], zero pad
  output logic        m_tuser,   // tilt_exceeded [0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for an input word
  localparam logic [2:0] ST_ANGLE = 3'd1;  // CORDIC running
  localparam logic [2:0] ST_BLEND = 3'd2;  // launch the multiplier
  localparam logic [2:0] ST_MUL   = 3'd3;  // multiplier running
  localparam logic [2:0] ST_OUT   = 3'd4;  // hand result to the output register

  logic [2:0] state;

  // Configuration registers
  logic signed [15:0] gyro_bias;
  logic signed [12:0] accel_angle_offset;
  logic [15:0]        blend_weight;
  logic [15:0]        tilt_limit;
  logic               cfg_wr;

  // Filter state and working registers
  logic signed [16:0] angle_estimate;
  logic signed [17:0] ag;           // angle after gyro step
  logic signed [17:0] acc_angle;    // accel angle plus offset
  logic signed [16:0] ang;          // saturated blended angle

  // Gyro path
  logic signed [15:0] accel_x, accel_z, gyro_y;
  logic signed [16:0] gsum;
  logic signed [15:0] gsat;
  logic signed [19:0] gneg5;
  logic signed [19:0] gneg5r;
  logic signed [12:0] delta;
  logic signed [17:0] ag_next;

  // Blend path
  logic                     cordic_done, mul_done, accept;
  logic signed [16:0]       cordic_angle;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod, prod_r;
  logic signed [DIFF_W-1:0] blend;
  logic signed [19:0]       ang_wide;
  logic [16:0]              mag;

  assign accel_x = s_tdata[15:0];
  assign accel_z = s_tdata[31:16];
  assign gyro_y  = s_tdata[47:32];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, write on the access cycle
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias          <= GYRO_BIAS_RST;
      accel_angle_offset <= ACCEL_OFFSET_RST;
      blend_weight       <= BLEND_WEIGHT_RST;
      tilt_limit         <= TILT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GYRO_BIAS:    gyro_bias          <= pwdata[15:0];
        REG_ACCEL_OFFSET: accel_angle_offset <= pwdata[12:0];
        REG_BLEND_WEIGHT: blend_weight       <= pwdata[15:0];
        REG_TILT_LIMIT:   tilt_limit         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Signed registers read back sign-extended
  always_comb begin
    case (paddr[3:2])
      REG_GYRO_BIAS:    prdata = {{16{gyro_bias[15]}}, gyro_bias};
      REG_ACCEL_OFFSET: prdata = {{19{accel_angle_offset[12]}}, accel_angle_offset};
      REG_BLEND_WEIGHT: prdata = {16'b0, blend_weight};
      REG_TILT_LIMIT:   prdata = {16'b0, tilt_limit};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Gyro step: saturate gyro + bias to 16 bits, delta = round(-g*5/128)
  // ---------------------------------------------------------------------------
  always_comb begin
    gsum = {gyro_y[15], gyro_y} + {gyro_bias[15], gyro_bias};
    if (gsum[16] != gsum[15]) begin
      gsat = gsum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      gsat = gsum[15:0];
    end
    gneg5   = -((20'(gsat) <<< 2) + 20'(gsat));
    gneg5r  = gneg5 + 20'sd64;
    delta   = gneg5r[19:7];
    ag_next = 18'(angle_estimate) + 18'(delta);
  end

  // ---------------------------------------------------------------------------
  // Accelerometer angle
  // ---------------------------------------------------------------------------
  cte_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .y_in  (accel_x),
    .x_in  (accel_z),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // ---------------------------------------------------------------------------
  // Blend: ag + round(w * (acc - ag) / 65536)
  // ---------------------------------------------------------------------------
  assign diff = DIFF_W'(acc_angle) - DIFF_W'(ag);

  cte_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_BLEND),
    .a     (diff),
    .b     (blend_weight),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    prod_r   = prod + PROD_W'(32768);
    blend    = prod_r[PROD_W-1:16];
    ang_wide = 20'(ag) + 20'(blend);
  end

  // Magnitude of the stored result for the limit check
  assign mag = ang[16] ? 17'(-ang) : 17'(ang);

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      ag <= ag_next;
    end
    if (state == ST_ANGLE && cordic_done) begin
      acc_angle <= 18'(cordic_angle) + 18'(accel_angle_offset);
    end
    if (state == ST_MUL && mul_done) begin
      // clamp to +-180 degrees
      if (ang_wide > 20'(ANGLE_MAX)) begin
        ang <= ANGLE_MAX;
      end else if (ang_wide < -20'(ANGLE_MAX)) begin
        ang <= -ANGLE_MAX;
      end else begin
        ang <= ang_wide[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      angle_estimate <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // raise valid when a result is handed over, drop it once the word is taken
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_ANGLE;
        end
        ST_ANGLE: begin
          if (cordic_done) state <= ST_BLEND;
        end
        ST_BLEND: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            angle_estimate <= ang;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'b0, acc_angle[16:0], ang};
      m_tuser <= (mag > {1'b0, tilt_limit});
    end
  end

endmodule

[hw/rtl/cte_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the complementary tilt estimator, bound to the top level.
// Depends on cte_pkg for the angle limit.
module cte_checker
  import cte_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Filtered angle stays inside +-180 degrees
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[16:0]) <= ANGLE_MAX &&
                  $signed(m_tdata[16:0]) >= -ANGLE_MAX))
    else $error("tilt angle out of range");

  // Reset drops the output
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // One word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

endmodule

bind complementary_tilt_estimator cte_checker u_cte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[test/tb_complementary_tilt_estimator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for complementary_tilt_estimator: streams IMU samples in,
// predicts every tilt result in-line and compares each result word field by field.
// Depends on cte_pkg (register indexes, atan table) and the RTL of the block.
module tb_complementary_tilt_estimator;
  import cte_pkg::*;

  localparam int CORDIC_STEPS  = 16;
  localparam int CLK_HALF      = 6;      // 12 ns period
  localparam int DRAIN_CYCLES  = 60;     // extra wait after the last result word is back
  localparam int STALL_LIMIT   = 20000;  // cycles with no handshake before giving up
  localparam int HOLD_OFF_LEN  = 400;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic signed [16:0] tilt_angle;
    logic signed [16:0] accel_angle;
    logic               tilt_exceeded;
  } tilt_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // accel_x [15:0], accel_z [31:16], gyro_y [47:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // tilt_angle [16:0], accel_angle [33:17], zero pad
  logic        m_tuser;   // tilt_exceeded [0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the configuration registers and of the stored angle
  longint cfg_gyro_bias;
  longint cfg_accel_offset;
  longint cfg_blend_weight;
  longint cfg_tilt_limit;
  longint est_angle;

  tilt_result_t pending_tilts[$];
  int mismatch_cnt;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_req;
  int hold_off_left;
  int quiet_cycles;

  complementary_tilt_estimator #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Vectoring CORDIC: atan2(y, x) in 1/256 degree. Pre-rotate by +-90 degrees when
  // x is negative so the whole circle is reachable; a zero vector gives zero.
  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    if (x == 0 && y == 0) return 0;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        z = 90 * 65536;
        t = x; x = y; y = -t;
      end else begin
        z = -90 * 65536;
        t = x; x = -y; y = t;
      end
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q16[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q16[i]);
      end
    end
    return (z + 128) >>> 8;
  endfunction

  // Advance the shadow angle by one sample and return the result it must produce.
  function automatic tilt_result_t predict_tilt(logic signed [15:0] ax,
                                                logic signed [15:0] az,
                                                logic signed [15:0] gy);
    tilt_result_t res;
    longint g;
    longint delta;
    longint acc;
    longint ag;
    longint ang;
    longint mag;
    g = longint'(gy) + cfg_gyro_bias;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    delta = (-g * 5 + 64) >>> 7;
    acc = cordic_angle(longint'(ax), longint'(az)) + cfg_accel_offset;
    ag = est_angle + delta;
    ang = ag + ((cfg_blend_weight * (acc - ag) + 32768) >>> 16);
    if (ang > longint'(ANGLE_MAX)) ang = longint'(ANGLE_MAX);
    if (ang < -longint'(ANGLE_MAX)) ang = -longint'(ANGLE_MAX);
    est_angle = ang;
    mag = (ang < 0) ? -ang : ang;
    res.tilt_angle    = ang[16:0];
    res.accel_angle   = acc[16:0];
    res.tilt_exceeded = (mag > cfg_tilt_limit);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one sample after a random gap; predict its result once it is taken.
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
                             logic signed [15:0] gy);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {gy, az, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_tilts.push_back(predict_tilt(ax, az, gy));
  endtask

  // Drop valid and hold until every predicted word is back and the pipe is empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tilts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write; fill unused upper bits with noise, the block masks them.
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    logic [31:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[31:16], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GYRO_BIAS:    cfg_gyro_bias    = longint'($signed(value));
      REG_ACCEL_OFFSET: cfg_accel_offset = longint'($signed(value[12:0]));
      REG_BLEND_WEIGHT: cfg_blend_weight = longint'(value);
      REG_TILT_LIMIT:   cfg_tilt_limit   = longint'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(logic signed [15:0] bias, logic signed [12:0] offset,
                            logic [15:0] weight, logic [15:0] limit);
    wait_idle();
    write_reg(REG_GYRO_BIAS, bias);
    write_reg(REG_ACCEL_OFFSET, {{3{offset[12]}}, offset});
    write_reg(REG_BLEND_WEIGHT, weight);
    write_reg(REG_TILT_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------

  // Receiver: either a counted hold-off or random stalls at the phase's rate.
  initial begin
    m_tready = 1'b0;
    hold_off_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        hold_off_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk) begin
    tilt_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tilts.size() == 0) begin
        $error("result word with no prediction waiting: tdata=%h tuser=%b", m_tdata, m_tuser);
        mismatch_cnt++;
      end else begin
        exp_res = pending_tilts.pop_front();
        if (m_tdata[16:0] !== exp_res.tilt_angle) begin
          $error("tilt_angle: expected %0d, got %0d", exp_res.tilt_angle,
                 $signed(m_tdata[16:0]));
          mismatch_cnt++;
        end
        if (m_tdata[33:17] !== exp_res.accel_angle) begin
          $error("accel_angle: expected %0d, got %0d", exp_res.accel_angle,
                 $signed(m_tdata[33:17]));
          mismatch_cnt++;
        end
        if (m_tuser !== exp_res.tilt_exceeded) begin
          $error("tilt_exceeded: expected %0b, got %0b", exp_res.tilt_exceeded, m_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any port.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, zero vector, the left half-plane and gyro saturation at reset config.
  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_sample(16'sd0, 16'sd0, 16'sd0);              // zero vector
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768); // gyro sum saturates low
    send_sample(16'sd0, -16'sd100, 16'sd75);          // straight back: +180
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    send_sample(16'sd100, -16'sd100, 16'sd0);
    send_sample(-16'sd100, -16'sd100, 16'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd0);          // +90
    send_sample(-16'sd32768, 16'sd0, 16'sd0);         // -90
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd1, 16'sd1, -16'sd1);
    send_sample(-16'sd1, -16'sd32768, 16'sd1);        // just below -180
    send_sample(16'sd16384, 16'sd16384, 16'sd128);
    send_sample(16'sd5555, -16'sd30000, -16'sd2000);
    wait_idle();
  endtask

  // Register extremes, including out-of-range offsets and angle saturation both ways.
  task automatic test_config_extremes();
    sender_idle_pct = 20;
    receiver_stall_pct = 20;
    // full accel weight, max bias: gyro sum saturates high, angle clips at +180
    set_config(16'sd32767, 13'sd4095, 16'hFFFF, 16'd0);
    send_sample(16'sd0, -16'sd100, 16'sd32767);
    send_sample(16'sd0, -16'sd1, 16'sd1);
    send_sample(16'sd200, 16'sd300, 16'sd0);
    // gyro only, min bias: the angle follows the gyro alone
    set_config(-16'sd32768, -13'sd4096, 16'd0, 16'hFFFF);
    send_sample(-16'sd1, -16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd32767, -16'sd1, 16'sd32767);
    // full accel weight pointing just past -180: angle clips at -180
    set_config(16'sd0, -13'sd2560, 16'hFFFF, 16'd46080);
    send_sample(-16'sd1, -16'sd32768, 16'sd0);
    send_sample(16'sd0, -16'sd1, 16'sd0);
    set_config(GYRO_BIAS_RST, ACCEL_OFFSET_RST, BLEND_WEIGHT_RST, TILT_LIMIT_RST);
  endtask

  // Hold the sink off while samples keep coming, so the block backs up its input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_req = HOLD_OFF_LEN;
    for (int i = 0; i < 12; i++) begin
      send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    wait_idle();
  endtask

  // Mostly plausible IMU readings with a share of full-range noise and zero axes.
  task automatic send_random_sample();
    int ax;
    int az;
    int gy;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        ax = int'($urandom_range(32767)) - 16384;
        az = int'($urandom_range(24000)) - 4000;
        gy = int'($urandom_range(4000)) - 2000;
      end
      5, 6, 7: begin
        ax = $urandom();
        az = $urandom();
        gy = $urandom();
      end
      8: begin
        ax = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(65535)) - 32768;
        az = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(65535)) - 32768;
        gy = $urandom();
      end
      default: begin
        ax = int'($urandom_range(2000)) - 1000;
        az = -int'($urandom_range(32768));
        gy = int'($urandom_range(65535)) - 32768;
      end
    endcase
    send_sample(ax[15:0], az[15:0], gy[15:0]);
  endtask

  // Four idle/stall profiles; each one after the first gets a fresh random register setting.
  task automatic test_random_phases();
    int idle_pct [4];
    int stall_pct[4];
    idle_pct  = '{0, 77, 0, 28};
    stall_pct = '{0, 0, 77, 28};
    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        set_config(16'($urandom()), 13'($urandom()), 16'($urandom()), 16'($urandom()));
      end
      sender_idle_pct = idle_pct[p];
      receiver_stall_pct = stall_pct[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_sample();
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_cnt = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_req = 0;
    quiet_cycles = 0;
    cfg_gyro_bias    = longint'(GYRO_BIAS_RST);
    cfg_accel_offset = longint'(ACCEL_OFFSET_RST);
    cfg_blend_weight = longint'(BLEND_WEIGHT_RST);
    cfg_tilt_limit   = longint'(TILT_LIMIT_RST);
    est_angle = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cte_pkg.sv
hw/rtl/cte_cordic.sv
hw/rtl/cte_mul.sv
hw/rtl/complementary_tilt_estimator.sv
hw/rtl/cte_checker.sv
test/tb_complementary_tilt_estimator.sv
